/* src/stable_priority_queue_macros.svh */
// Assertion macros for the priority queue RTL.
// Included by stable_priority_queue, which carries concurrent assertions; no other dependencies.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the active-low reset is asserted.
`define SPQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The same on the block clock and reset.
`define SPQ_ASSERT(lbl, prop, msg) `SPQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* src/spq_pkg.sv */
// Package for the stable priority queue: sizes, codes, entry and command types.
// Used by spq_cell, stable_priority_queue and the testbench; depends on nothing else.
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int ELEMENT_BITS  = 16;
  localparam int PRIORITY_BITS = 16;
  localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

  // Saturation limits of the stored priority, held wide enough for priority widths up to 33 bits.
  localparam logic signed [32:0] PRIO_MAX_W = 33'((longint'(1) << (PRIORITY_BITS - 1)) - 1);
  localparam logic signed [32:0] PRIO_MIN_W = -PRIO_MAX_W - 33'sd1;

  typedef logic [ELEMENT_BITS-1:0]         elem_t;
  typedef logic signed [PRIORITY_BITS-1:0] prio_t;
  typedef logic [COUNT_BITS-1:0]           count_t;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_MODIFY  = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_NOP,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    logic  valid;
    elem_t elem;
    prio_t prio;
  } entry_t;

  // Command broadcast to every cell in the same cycle.
  typedef struct packed {
    cell_op_e op;
    elem_t    elem;
    prio_t    prio;
    logic     head;
  } cell_cmd_t;

  // Clamps a 16-bit signed request priority to the stored priority range.
  function automatic prio_t sat_prio(input logic signed [15:0] p);
    logic signed [32:0] w;
    w = 33'(p);
    if (w > PRIO_MAX_W) begin
      w = PRIO_MAX_W;
    end else if (w < PRIO_MIN_W) begin
      w = PRIO_MIN_W;
    end
    return prio_t'(w);
  endfunction

endpackage

/* src/spq_cell.sv */
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
// Depends on spq_pkg for the entry and command types.
module spq_cell import spq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  entry_t    left_entry_i,
  input  logic      left_keeps_i,
  input  logic      found_i,
  input  entry_t    right_entry_i,
  output entry_t    entry_o,
  output logic      keeps_o,
  output logic      found_o
);

  logic  valid_q, valid_d;
  elem_t elem_q, elem_d;
  prio_t prio_q, prio_d;

  // A cell keeps its entry on insert when its priority is not below the new one.
  assign keeps_o = valid_q && (prio_q >= cmd_i.prio);
  // Set from the first matching entry onward; everything at or behind it moves up.
  assign found_o = found_i || (valid_q && (elem_q == cmd_i.elem));

  assign entry_o = '{valid: valid_q, elem: elem_q, prio: prio_q};

  always_comb begin
    valid_d = valid_q;
    elem_d  = elem_q;
    prio_d  = prio_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (!left_keeps_i) begin
          valid_d = left_entry_i.valid;
          elem_d  = left_entry_i.elem;
          prio_d  = left_entry_i.prio;
        end else if (!keeps_o) begin
          valid_d = 1'b1;
          elem_d  = cmd_i.elem;
          prio_d  = cmd_i.prio;
        end
      end
      CELL_REMOVE: begin
        if (found_o) begin
          valid_d = right_entry_i.valid;
          elem_d  = right_entry_i.elem;
          prio_d  = right_entry_i.prio;
        end
      end
      CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    prio_q <= prio_d;
  end

endmodule

/* src/stable_priority_queue.sv */
// Top level of the stable priority queue: request/result streams, control and the cell row.
// Depends on spq_pkg, spq_cell and stable_priority_queue_macros.svh.
//
// A bounded max-priority queue of CAPACITY entries held in a row of cells, sorted by
// descending priority with first-in-first-out order among equal priorities. Every cell
// compares its own entry with the broadcast request in the same cycle and either holds,
// takes the new entry, or takes its neighbor's entry, so insert and remove each finish in
// a single update of the cells at any position. A request is taken only while the control
// is idle. Insert, extract and clear update the cells as the request is accepted and then
// load the result register in the report state, which waits while the output register is
// full; modify key first removes the matching entry and then reinserts it in a second pass
// over the row, in the reinsert state, before its report. The next request is accepted
// once the result has been loaded, so the block takes no new request while one is still
// in progress. The search for the first matching element is a one-bit ripple through
// the row, which sets the longest path of a remove. The queue comes out of reset empty;
// stored elements and priorities are not reset, only the per-cell valid flags.
// Request: tuser carries the opcode, tdata the element and the priority. Result: tdata
// carries status, extracted element, head valid, head element and occupancy.
`include "stable_priority_queue_macros.svh"

module stable_priority_queue import spq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] element, [31:16] priority_req (signed)
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [1:0] status, [17:2] extracted_element,
                                      // [18] head_valid, [34:19] head_element,
                                      // [39:35] occupancy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REINSERT,
    S_REPORT
  } state_e;

  state_e      state_q;
  count_t      count_q;
  status_e     status_q;
  logic [15:0] extracted_q;
  elem_t       key_q;
  prio_t       prio_q;
  logic        found_q;
  logic        m_valid_q;
  logic [39:0] m_data_q;

  logic      accept;
  op_e       in_op;
  elem_t     in_elem;
  prio_t     in_prio;
  cell_cmd_t cmd;

  entry_t                entries [CAPACITY];
  logic [CAPACITY-1:0]   keeps;
  logic [CAPACITY:0]     found;
  logic [CAPACITY-1:0]   valid_vec;

  logic [1:0] out_status;
  logic       out_head_valid;
  logic [4:0] out_occupancy;
  logic       res_full;
  logic       res_empty;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_op         = op_e'(s_axis_tuser);
  assign in_elem       = elem_t'(s_axis_tdata[15:0]);
  assign in_prio       = sat_prio(s_axis_tdata[31:16]);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The command for the row: the accepted request, or the second pass of modify key.
  always_comb begin
    cmd = '{op: CELL_NOP, elem: in_elem, prio: in_prio, head: 1'b0};
    if (state_q == S_REINSERT) begin
      cmd.elem = key_q;
      cmd.prio = prio_q;
      cmd.op   = found_q ? CELL_INSERT : CELL_NOP;
    end else if (accept) begin
      case (in_op)
        OP_INSERT: begin
          if (count_q < count_t'(CAPACITY)) begin
            cmd.op = CELL_INSERT;
          end
        end
        OP_EXTRACT: begin
          cmd.op   = CELL_REMOVE;
          cmd.head = 1'b1;
        end
        OP_MODIFY: begin
          cmd.op = CELL_REMOVE;
        end
        OP_CLEAR: begin
          cmd.op = CELL_CLEAR;
        end
        default: begin
        end
      endcase
    end
  end

  // Extract-max starts the shift at the head; modify key starts it at the first match.
  assign found[0] = cmd.head;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_entry;
    logic   left_keeps;
    entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_keeps = 1'b1;
    end else begin : g_inner_left
      assign left_entry = entries[i-1];
      assign left_keeps = keeps[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner_right
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_entry_i (left_entry),
      .left_keeps_i (left_keeps),
      .found_i      (found[i]),
      .right_entry_i(right_entry),
      .entry_o      (entries[i]),
      .keeps_o      (keeps[i]),
      .found_o      (found[i+1])
    );

    assign valid_vec[i] = entries[i].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      status_q    <= STATUS_OK;
      extracted_q <= '0;
      key_q       <= '0;
      prio_q      <= '0;
      found_q     <= 1'b0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      // A new result is loaded when the output register is free or being emptied.
      if ((state_q == S_REPORT) && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            key_q   <= in_elem;
            prio_q  <= in_prio;
            state_q <= (in_op == OP_MODIFY) ? S_REINSERT : S_REPORT;
            case (in_op)
              OP_INSERT: begin
                extracted_q <= '0;
                if (count_q < count_t'(CAPACITY)) begin
                  status_q <= STATUS_OK;
                  count_q  <= count_q + count_t'(1);
                end else begin
                  status_q <= STATUS_FULL;
                end
              end
              OP_EXTRACT: begin
                if (count_q == '0) begin
                  status_q    <= STATUS_EMPTY;
                  extracted_q <= '0;
                end else begin
                  status_q    <= STATUS_OK;
                  extracted_q <= 16'(entries[0].elem);
                  count_q     <= count_q - count_t'(1);
                end
              end
              OP_MODIFY: begin
                extracted_q <= '0;
                found_q     <= found[CAPACITY];
                if (found[CAPACITY]) begin
                  status_q <= STATUS_OK;
                  count_q  <= count_q - count_t'(1);
                end else begin
                  status_q <= STATUS_NOT_FOUND;
                end
              end
              OP_CLEAR: begin
                extracted_q <= '0;
                status_q    <= STATUS_OK;
                count_q     <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_REINSERT: begin
          if (found_q) begin
            count_q <= count_q + count_t'(1);
          end
          state_q <= S_REPORT;
        end
        S_REPORT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= {5'(count_q),
                          entries[0].valid ? 16'(entries[0].elem) : 16'd0,
                          entries[0].valid,
                          extracted_q,
                          2'(status_q)};
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_status     = m_data_q[1:0];
  assign out_head_valid = m_data_q[18];
  assign out_occupancy  = m_data_q[39:35];
  assign res_full       = m_axis_tvalid && (out_status == STATUS_FULL);
  assign res_empty      = m_axis_tvalid && (out_status == STATUS_EMPTY);

  // The count register always agrees with the number of occupied cells.
  `SPQ_ASSERT(a_count_match, ($countones(valid_vec) == int'(count_q)), "count differs")
  // Occupied cells form an unbroken run from the head.
  `SPQ_ASSERT(a_valid_prefix, ((valid_vec & (valid_vec + CAPACITY'(1))) == '0), "gap in row")
  // A dropped insert is only reported when the queue really is full.
  `SPQ_ASSERT(a_full_status, (res_full |-> (out_occupancy == 5'(CAPACITY))), "full with room")
  // An empty extract leaves the queue empty.
  `SPQ_ASSERT(a_empty_status, (res_empty |-> (!out_head_valid && (out_occupancy == 5'd0))), "not empty")

endmodule

/* tb/spq_result_checker.sv */
// Result checker for the stable priority queue: keeps its own copy of the sorted queue,
// predicts one result per accepted request and compares it with the result stream.
// Depends on spq_pkg for sizes, opcodes and status codes.
module spq_result_checker import spq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] element, [31:16] priority_req (signed)
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // [1:0] status, [17:2] extracted_element,
                                      // [18] head_valid, [34:19] head_element,
                                      // [39:35] occupancy
  output int unsigned outstanding_o,
  output int unsigned errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PRIO_CEIL  = (longint'(1) << (PRIORITY_BITS - 1)) - 1;
  localparam longint PRIO_FLOOR = -PRIO_CEIL - 1;

  typedef struct packed {
    status_e status;
    elem_t   extracted;
    logic    head_valid;
    elem_t   head;
    count_t  occupancy;
  } queue_result_t;

  // Shadow of the queue contents, head at index zero.
  elem_t         slot_elem [CAPACITY];
  longint        slot_prio [CAPACITY];
  int unsigned   slot_count;
  queue_result_t pending_results[$];
  int unsigned   mismatches;

  function automatic void drop_slot(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < slot_count; i++) begin
      slot_elem[i] = slot_elem[i + 1];
      slot_prio[i] = slot_prio[i + 1];
    end
    slot_count--;
  endfunction

  // New entries go behind every entry of greater or equal priority.
  function automatic void place_entry(input elem_t e, input longint p);
    int unsigned pos;
    pos = 0;
    while (pos < slot_count && slot_prio[pos] >= p) pos++;
    for (int unsigned i = slot_count; i > pos; i--) begin
      slot_elem[i] = slot_elem[i - 1];
      slot_prio[i] = slot_prio[i - 1];
    end
    slot_elem[pos] = e;
    slot_prio[pos] = p;
    slot_count++;
  endfunction

  function automatic queue_result_t apply_request(input op_e op, input elem_t e,
                                                  input longint p);
    queue_result_t r;
    int unsigned   hit;
    bit            found;
    r = '0;
    r.status = STATUS_OK;
    hit = 0;
    found = 1'b0;
    case (op)
      OP_INSERT: begin
        if (slot_count >= CAPACITY) r.status = STATUS_FULL;
        else place_entry(e, p);
      end
      OP_EXTRACT: begin
        if (slot_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.extracted = slot_elem[0];
          drop_slot(0);
        end
      end
      OP_MODIFY: begin
        for (int unsigned i = 0; i < slot_count && !found; i++) begin
          if (slot_elem[i] == e) begin
            found = 1'b1;
            hit = i;
          end
        end
        if (!found) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          drop_slot(hit);
          place_entry(e, p);
        end
      end
      default: slot_count = 0;
    endcase
    r.head_valid = (slot_count != 0);
    r.head       = (slot_count != 0) ? slot_elem[0] : '0;
    r.occupancy  = count_t'(slot_count);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    queue_result_t got;
    longint        prio;
    if (!rst_ni) begin
      slot_count = 0;
      mismatches = 0;
      pending_results.delete();
      outstanding_o <= 0;
      errors_o <= 0;
    end else begin
      // Requests are taken before results, so a result seen in the same cycle is
      // still matched against the oldest request.
      if (s_axis_tvalid && s_axis_tready) begin
        prio = longint'($signed(s_axis_tdata[31:16]));
        if (prio > PRIO_CEIL) prio = PRIO_CEIL;
        if (prio < PRIO_FLOOR) prio = PRIO_FLOOR;
        pending_results.push_back(apply_request(op_e'(s_axis_tuser),
                                                elem_t'(s_axis_tdata[15:0]), prio));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status     = status_e'(m_axis_tdata[1:0]);
        got.extracted  = m_axis_tdata[17:2];
        got.head_valid = m_axis_tdata[18];
        got.head       = m_axis_tdata[34:19];
        got.occupancy  = m_axis_tdata[39:35];
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %h arrived with no request outstanding", $realtime,
                     m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.extracted !== want.extracted ||
              got.head_valid !== want.head_valid || got.head !== want.head ||
              got.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: mismatch status %0d/%0d extracted %h/%h head_valid %b/%b ",
                     $realtime, want.status, got.status, want.extracted, got.extracted,
                     want.head_valid, got.head_valid);
              $display("head %h/%h occupancy %0d/%0d (expected/actual)",
                       want.head, got.head, want.occupancy, got.occupancy);
            end
          end
        end
      end
      outstanding_o <= pending_results.size();
      errors_o <= mismatches;
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the stable priority queue testbench: clock, reset, request stimulus, result
// backpressure, watchdog and verdict. Depends on spq_pkg, spq_result_checker and the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int RANDOM_REQUESTS = 1930;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASE_LENGTH    = 48;

  // Traffic mixes of the random part. A fill phase drives the queue into the full
  // state, a drain phase empties it, and the balanced mix gives inserts and extracts about equal shares.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } traffic_mix_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  int unsigned outstanding;
  int unsigned errors;
  int unsigned quiet_cycles = 0;
  // While set, neither side idles: the bench offers requests without gaps and keeps the result side ready.
  bit          steady = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stable_priority_queue i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  spq_result_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  // Outside the steady stretch the result side stalls at random, with a chance of about 15 in 100.
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 15);
  end

  // Ends the run when neither stream has moved for too long. The slowest correct request,
  // modify key, adds a reinsert pass and may meet a short random stall; the limit is generous.
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request and returns at the edge where it is accepted. Random idle
  // cycles come only before tvalid is raised, so a request once offered stays up.
  task automatic send_request(input op_e op, input elem_t e, input logic [15:0] p);
    while (!steady && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {p, e};
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Holds the request side until every outstanding result has been returned.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    traffic_mix_e mix;
    elem_t        tag_pool[8];
    int unsigned  roll;
    int unsigned  insert_pct;
    int unsigned  extract_pct;
    op_e          op;
    elem_t        e;
    logic [15:0]  p;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the empty-queue cases, the priority extremes, first-in-first-out
    // order among equal priorities, the first of two equal elements being the one that
    // modify key moves, a miss in modify key, and clear.
    send_request(OP_CLEAR,   16'h0000, 16'h0000);
    send_request(OP_EXTRACT, 16'h0000, 16'h0000);
    send_request(OP_MODIFY,  16'hAAAA, 16'h0003);
    send_request(OP_INSERT,  16'h0000, 16'h8000);
    send_request(OP_INSERT,  16'hFFFF, 16'h7FFF);
    send_request(OP_INSERT,  16'h1234, 16'h7FFF);
    send_request(OP_INSERT,  16'h5555, 16'h0000);
    send_request(OP_INSERT,  16'h5555, 16'h0000);
    send_request(OP_MODIFY,  16'hFFFF, 16'h7FFF);
    send_request(OP_MODIFY,  16'h5555, 16'h7FFF);
    send_request(OP_MODIFY,  16'hBEEF, 16'h0001);
    send_request(OP_MODIFY,  16'h0000, 16'hFFFF);
    send_request(OP_EXTRACT, 16'hFFFF, 16'hFFFF);
    send_request(OP_EXTRACT, 16'h0000, 16'h0000);
    send_request(OP_EXTRACT, 16'h0000, 16'h0000);
    send_request(OP_INSERT,  16'hA5A5, 16'h8000);
    send_request(OP_CLEAR,   16'hFFFF, 16'hFFFF);
    send_request(OP_EXTRACT, 16'h0000, 16'h0000);
    send_request(OP_INSERT,  16'h5A5A, 16'h0001);
    send_request(OP_EXTRACT, 16'h0000, 16'h0000);
    send_request(OP_EXTRACT, 16'h0000, 16'h0000);
    wait_for_results();

    // Random part. Elements come mostly from a small pool that is redrawn each phase,
    // so duplicates are stored and modify key usually finds a match; half of the priorities
    // come from a narrow band, so equal priorities are common.
    mix = MIX_FILL;
    insert_pct = 70;
    extract_pct = 12;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % PHASE_LENGTH == 0) begin
        mix = traffic_mix_e'($urandom_range(2));
        foreach (tag_pool[k]) tag_pool[k] = elem_t'($urandom);
        case (mix)
          MIX_FILL: begin
            insert_pct = 70;
            extract_pct = 12;
          end
          MIX_DRAIN: begin
            insert_pct = 25;
            extract_pct = 55;
          end
          default: begin
            insert_pct = 42;
            extract_pct = 38;
          end
        endcase
      end
      steady = (n >= 700 && n < 1000);
      if (n == 1300) wait_for_results();

      roll = $urandom_range(99);
      if (roll < insert_pct) op = OP_INSERT;
      else if (roll < insert_pct + extract_pct) op = OP_EXTRACT;
      else if (roll < 98) op = OP_MODIFY;
      else op = OP_CLEAR;

      e = ($urandom_range(99) < 80) ? tag_pool[$urandom_range(7)] : elem_t'($urandom);

      roll = $urandom_range(99);
      if (roll < 50) p = 16'($urandom_range(3)) - 16'd2;
      else if (roll < 80) p = 16'($urandom);
      else if (roll < 90) p = 16'h7FFF;
      else p = 16'h8000;

      send_request(op, e, p);
    end
    steady = 1'b0;

    // Drain: wait for the last results, then let the clock run on for stray output.
    wait_for_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/stable_priority_queue.sv
tb/spq_result_checker.sv
tb/testbench.sv
